FILE: hw/rtl/kuf_pkg.sv
// Shared types and constants for the union-find edge filter.
package kuf_pkg;

    // Widths of the stream fields
    localparam int VERT_W   = 8;
    localparam int WEIGHT_W = 32;
    localparam int CNT_W    = 9;
    localparam int IDX_W    = 8;

    // Largest vertex count the edge format can address
    localparam int VERT_LIMIT = 256;

    // vertex_count after reset
    localparam logic [CNT_W-1:0] VC_RESET = 9'd256;

    // Register index on the APB port (byte address bit 2)
    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

    // Control from the sequencer to the parent table
    typedef struct packed {
        logic clear;   // mark every vertex as its own parent
        logic wr_en;   // link one root to another
    } kuf_mem_ctl_t;

endpackage

FILE: hw/rtl/kuf_parent_mem.sv
// Parent pointer table with per-entry valid bits and a registered read port.
module kuf_parent_mem #(
    parameter int DEPTH = 256,
    parameter int IW    = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kuf_pkg::kuf_mem_ctl_t ctl,
    input  logic [IW-1:0]         rd_addr,
    input  logic [IW-1:0]         wr_addr,
    input  logic [IW-1:0]         wr_data,
    output logic [IW-1:0]         rd_parent
);
    import kuf_pkg::*;

    logic [IW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [IW-1:0]    rd_data_reg;
    logic             rd_valid_reg;
    logic [IW-1:0]    rd_addr_reg;

    // Store a link
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Valid bits: clear on reset or new graph, set on link
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.clear) begin
            valid_reg <= '0;
        end else if (ctl.wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read of entry and its valid bit
    always_ff @(posedge aclk) begin
        rd_data_reg  <= mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
        rd_addr_reg  <= rd_addr;
    end

    // An entry never linked points at itself
    assign rd_parent = rd_valid_reg ? rd_data_reg : rd_addr_reg;

endmodule

FILE: hw/rtl/kruskal_union_find_edge_filter.sv
// Kruskal tree-edge filter: walks a union-find forest and emits spanning tree edges.
//
// Usage: edges arrive on the s_ stream sorted by ascending weight. s_tuser marks the
// first edge of a graph; that transfer resets the forest and the tree edge count.
// Each edge whose endpoints lie in different trees leaves on the m_ stream as a tree
// edge, lower vertex first, with its position in the tree; m_tlast flags the edge
// that completes the tree. Rejected, out-of-range and post-completion edges give no
// transfer. vertex_count is to be written over the APB port only while the block is
// idle; the block does not enforce this. One edge is in work at a time; s_tready is
// low meanwhile. A dropped edge ends in idle; any other edge goes through load, the
// low-root walk and the high-root walk, then emit if its roots differ. Each walk step
// is one read of the parent table's read port. The output register frees the walk
// from the receiver: a stalled m_ side delays only the next tree edge's emit step.
// Reset: synchronous, active low; all vertices become roots, the count clears and
// vertex_count returns to 256. No clearing pass is needed: valid bits clear at once.
module kruskal_union_find_edge_filter #(
    parameter int MAX_VERTICES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Edge input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // end_a[7:0], end_b[15:8], edge_weight[47:16]
    input  logic [0:0]  s_tuser,   // first_edge[0]
    // Tree edge output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // low_vertex[7:0], high_vertex[15:8],
                                   // tree_weight[47:16], tree_index[55:48]
    output logic        m_tlast    // tree_done
);
    import kuf_pkg::*;

    localparam int DEPTH = (MAX_VERTICES < VERT_LIMIT) ? MAX_VERTICES : VERT_LIMIT;
    localparam int IW    = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_N = CNT_W'(DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_LOAD    = 5'b00010,
        ST_WALK_LO = 5'b00100,
        ST_WALK_HI = 5'b01000,
        ST_EMIT    = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           vc_reg;
    logic [IDX_W-1:0]           acc_reg, acc_next;
    logic [VERT_W-1:0]          lo_reg, lo_next, hi_reg, hi_next;
    logic signed [WEIGHT_W-1:0] weight_reg, weight_next;
    logic [IW-1:0]              cur_reg, cur_next, rlo_reg, rlo_next, rhi_reg, rhi_next;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [VERT_W-1:0]          out_lo_reg, out_hi_reg;
    logic signed [WEIGHT_W-1:0] out_weight_reg;
    logic [IDX_W-1:0]           out_idx_reg;
    logic                       out_done_reg;
    logic                       out_load;

    logic [CNT_W-1:0]  eff_n, n_minus1;
    logic [VERT_W-1:0] in_a, in_b;
    logic [IDX_W-1:0]  cnt_start;
    logic              in_accept, in_drop, out_free, cfg_write;
    logic [IW-1:0]     rd_addr, rd_parent;
    kuf_mem_ctl_t      mem_ctl;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_VERTEX_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= VC_RESET;
        end else if (cfg_write) begin
            vc_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {{(32-CNT_W){1'b0}}, vc_reg} : '0;

    // Effective vertex count
    assign eff_n    = (vc_reg > DEPTH_N) ? DEPTH_N : vc_reg;
    assign n_minus1 = eff_n - CNT_W'(1);

    // Input decode and drop check
    assign in_a      = s_tdata[7:0];
    assign in_b      = s_tdata[15:8];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cnt_start = s_tuser[0] ? '0 : acc_reg;
    assign in_drop   = (eff_n == '0) || ({1'b0, in_a} >= eff_n) || ({1'b0, in_b} >= eff_n)
                       || ({1'b0, cnt_start} >= n_minus1);

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer: load, walk low root, walk high root, emit
    always_comb begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        weight_next   = weight_reg;
        cur_next      = cur_reg;
        rlo_next      = rlo_reg;
        rhi_next      = rhi_reg;
        rd_addr       = cur_reg;
        mem_ctl       = '0;
        out_load      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser[0]) begin
                        mem_ctl.clear = 1'b1;
                        acc_next      = '0;
                    end
                    if (!in_drop) begin
                        lo_next     = (in_a < in_b) ? in_a : in_b;
                        hi_next     = (in_a < in_b) ? in_b : in_a;
                        weight_next = s_tdata[47:16];
                        state_next  = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                rd_addr    = lo_reg[IW-1:0];
                cur_next   = lo_reg[IW-1:0];
                state_next = ST_WALK_LO;
            end
            ST_WALK_LO: begin
                if (rd_parent == cur_reg) begin
                    rlo_next   = cur_reg;
                    rd_addr    = hi_reg[IW-1:0];
                    cur_next   = hi_reg[IW-1:0];
                    state_next = ST_WALK_HI;
                end else begin
                    rd_addr  = rd_parent;
                    cur_next = rd_parent;
                end
            end
            ST_WALK_HI: begin
                if (rd_parent == cur_reg) begin
                    rhi_next   = cur_reg;
                    state_next = (cur_reg == rlo_reg) ? ST_IDLE : ST_EMIT;
                end else begin
                    rd_addr  = rd_parent;
                    cur_next = rd_parent;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    mem_ctl.wr_en = 1'b1;
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    acc_next      = acc_reg + IDX_W'(1);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Work registers
    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        weight_reg <= weight_next;
        cur_reg    <= cur_next;
        rlo_reg    <= rlo_next;
        rhi_reg    <= rhi_next;
    end

    // Output register: hold until transfer
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_lo_reg     <= lo_reg;
            out_hi_reg     <= hi_reg;
            out_weight_reg <= weight_reg;
            out_idx_reg    <= acc_reg;
            out_done_reg   <= ({1'b0, acc_reg} + CNT_W'(1)) == n_minus1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_idx_reg, out_weight_reg, out_hi_reg, out_lo_reg};
    assign m_tlast  = out_done_reg;

    // Parent table
    kuf_parent_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_parent_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (mem_ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (rlo_reg),
        .wr_data   (rhi_reg),
        .rd_parent (rd_parent)
    );

`ifndef ASSERT_OFF
    // A link always joins two distinct roots
    a_link_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (rlo_reg != rhi_reg))
        else $error("link of a root to itself");

    // An emitted edge carries the count before it was taken
    a_emit_index: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_tvalid && (m_tdata[55:48] == $past(acc_reg))))
        else $error("tree index mismatch");

    // A new graph clears the tree edge count
    a_first_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_tuser[0]) |=> (acc_reg == '0))
        else $error("count not cleared on new graph");
`endif

endmodule

FILE: sim/tb_top.sv
// Testbench for the Kruskal union-find edge filter: edge stimulus, tree-edge prediction, checks.
`timescale 1ns / 1ps

module tb_top;
    import kuf_pkg::*;

    localparam int          MAX_VERT         = 256;
    // Longest edge: two full-depth walks plus the emit step
    localparam int          SETTLE_CYCLES    = 600;
    localparam int          HOLD_CYCLES      = 2000;
    localparam int          LIMIT_CYCLES     = 4000000;

    typedef struct packed {
        logic [VERT_W-1:0]   low_vertex;
        logic [VERT_W-1:0]   high_vertex;
        logic [WEIGHT_W-1:0] tree_weight;
        logic [IDX_W-1:0]    tree_index;
        logic                tree_done;
    } tree_edge_t;

    // Forest shadow and queue of tree edges still owed by the block
    class mst_edge_scoreboard;
        logic [VERT_W-1:0] parent_of [MAX_VERT];
        int unsigned       tree_count;
        logic [CNT_W-1:0]  vcount;
        tree_edge_t        pending_edges [$];
        int unsigned       errors;
        int unsigned       matched;

        function new();
            vcount = VC_RESET;
            errors = 0;
            matched = 0;
            clear_forest();
        endfunction

        function void clear_forest();
            for (int i = 0; i < MAX_VERT; i++) parent_of[i] = i[VERT_W-1:0];
            tree_count = 0;
        endfunction

        function void set_vertex_count(logic [CNT_W-1:0] val);
            vcount = val;
        endfunction

        function int unsigned pending();
            return pending_edges.size();
        endfunction

        // Walk parent pointers up to the root, bounded at MAX_VERT steps
        function logic [VERT_W-1:0] root_of(logic [VERT_W-1:0] v);
            for (int s = 0; s < MAX_VERT; s++) begin
                if (parent_of[v] == v) break;
                v = parent_of[v];
            end
            return v;
        endfunction

        // Predict the outcome of one accepted edge
        function void note_edge(bit first, logic [VERT_W-1:0] a, logic [VERT_W-1:0] b,
                                logic [WEIGHT_W-1:0] w);
            int unsigned       n;
            logic [VERT_W-1:0] lo, hi, rlo, rhi;
            tree_edge_t        e;
            if (first) clear_forest();
            n = 32'(vcount);
            if (n > VERT_LIMIT) n = VERT_LIMIT;
            if (n > MAX_VERT) n = MAX_VERT;
            // drop out-of-range endpoints, ignore once the tree is complete
            if (n == 0 || a >= n || b >= n) return;
            if (tree_count >= n - 1) return;
            lo  = (a < b) ? a : b;
            hi  = (a < b) ? b : a;
            rlo = root_of(lo);
            rhi = root_of(hi);
            if (rlo == rhi) return;
            parent_of[rlo] = rhi;
            e.low_vertex  = lo;
            e.high_vertex = hi;
            e.tree_weight = w;
            e.tree_index  = tree_count[IDX_W-1:0];
            tree_count++;
            e.tree_done   = (tree_count == n - 1);
            pending_edges.push_back(e);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("[%0t] mismatch in %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
            errors++;
        endtask

        // Compare one output transfer with the oldest prediction
        task check_tree_edge(logic [55:0] data, logic last);
            tree_edge_t want;
            if (pending_edges.size() == 0) begin
                report_mismatch("unexpected tree edge", data, 0);
                return;
            end
            want = pending_edges.pop_front();
            if (data[7:0] != want.low_vertex)
                report_mismatch("low_vertex", data[7:0], want.low_vertex);
            if (data[15:8] != want.high_vertex)
                report_mismatch("high_vertex", data[15:8], want.high_vertex);
            if (data[47:16] != want.tree_weight)
                report_mismatch("tree_weight", data[47:16], want.tree_weight);
            if (data[55:48] != want.tree_index)
                report_mismatch("tree_index", data[55:48], want.tree_index);
            if (last != want.tree_done)
                report_mismatch("tree_done", last, want.tree_done);
            matched++;
        endtask
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // end_a[7:0], end_b[15:8], edge_weight[47:16]
    logic [0:0]  s_tuser  = '0;   // first_edge[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // low_vertex[7:0], high_vertex[15:8],
                                  // tree_weight[47:16], tree_index[55:48]
    logic        m_tlast;         // tree_done

    mst_edge_scoreboard tree_sb;
    int unsigned src_idle_pct = 0;
    int unsigned dst_idle_pct = 0;
    bit          hold_go      = 1'b0;
    logic        hold_active  = 1'b0;
    int unsigned cycle_count  = 0;
    int unsigned items_sent   = 0;
    int unsigned graphs_sent  = 0;
    int unsigned vc_writes    = 0;

    kruskal_union_find_edge_filter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Receive tree edges; stall at random or for the long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) tree_sb.check_tree_edge(m_tdata, m_tlast);
            if (hold_active) m_tready <= 1'b0;
            else m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Hold the output side off for a long stretch once asked to
    initial begin : long_hold
        wait (hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active <= 1'b0;
    end

    // Offer one edge and wait for its transfer
    task automatic send_edge(input bit first, input logic [7:0] a, input logic [7:0] b,
                             input logic [31:0] w);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tdata  <= {w, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tree_sb.note_edge(first, a, b, w);
        items_sent++;
    endtask

    // Stop offering, let every owed edge arrive, then let the walk settle
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tree_sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write of vertex_count: setup then access
    task automatic write_vertex_count(input logic [CNT_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_VERTEX_COUNT, 2'b00};
        pwdata  <= {{(32 - CNT_W){1'b0}}, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tree_sb.set_vertex_count(val);
        vc_writes++;
    endtask

    // Noise edge: possible cycle, self loop, out-of-range endpoint or fully random
    task automatic pick_noise(input int unsigned nv, output logic [7:0] a, output logic [7:0] b);
        case ($urandom_range(3))
            0: begin
                a = (nv == 0) ? 8'($urandom) : 8'($urandom_range(nv - 1));
                b = (nv == 0) ? 8'($urandom) : 8'($urandom_range(nv - 1));
            end
            1: begin
                a = (nv == 0) ? 8'($urandom) : 8'($urandom_range(nv - 1));
                b = a;
            end
            2: begin
                a = (nv >= VERT_LIMIT) ? 8'($urandom) : 8'($urandom_range(VERT_LIMIT - 1, nv));
                b = 8'($urandom);
                if ($urandom_range(1)) {a, b} = {b, a};
            end
            default: begin
                a = 8'($urandom);
                b = 8'($urandom);
            end
        endcase
    endtask

    // One graph: a random spanning tree in order, noise mixed in, some edges after completion
    task automatic send_graph(input int unsigned vc, input int unsigned budget);
        int unsigned nv, sent, cut, j;
        logic [7:0]  order [VERT_LIMIT];
        logic [7:0]  a, b, tmp;
        logic [31:0] w;
        bit          first;
        nv = (vc > VERT_LIMIT) ? VERT_LIMIT : vc;
        for (int i = 0; i < VERT_LIMIT; i++) order[i] = i[7:0];
        for (int i = int'(nv) - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        w     = $urandom;
        first = ($urandom_range(99) >= 10);
        sent  = 0;
        // some sequences break off early
        cut   = ($urandom_range(99) < 15 && nv > 1) ? $urandom_range(1, nv - 1) : nv;
        if (nv < 2) begin
            repeat ($urandom_range(3, 8)) begin
                if (sent >= budget) break;
                pick_noise(nv, a, b);
                send_edge(first, a, b, w);
                first = 1'b0;
                w = w + $urandom_range(0, 3000);
                sent++;
            end
        end else begin
            for (int i = 1; i < int'(cut); i++) begin
                if (sent >= budget) break;
                if ($urandom_range(99) < 25) begin
                    pick_noise(nv, a, b);
                end else begin
                    a = order[i];
                    b = order[$urandom_range(i - 1)];
                    if ($urandom_range(1)) {a, b} = {b, a};
                end
                send_edge(first, a, b, w);
                first = 1'b0;
                w = w + $urandom_range(0, 3000);
                sent++;
            end
            repeat ($urandom_range(0, 4)) begin
                if (sent >= budget) break;
                pick_noise(nv, a, b);
                send_edge(first, a, b, w);
                first = 1'b0;
                w = w + $urandom_range(0, 3000);
                sent++;
            end
        end
        graphs_sent++;
    endtask

    // Field extremes, rejection, self loop, range drop, completion, odd counts
    task automatic run_directed();
        send_edge(1'b1, 8'd0, 8'd255, 32'h8000_0000);
        send_edge(1'b0, 8'd255, 8'd0, 32'h0000_0000);
        send_edge(1'b0, 8'd7, 8'd7, 32'h0000_0001);
        send_edge(1'b0, 8'd170, 8'd85, 32'h7FFF_FFFF);
        send_edge(1'b0, 8'd85, 8'd170, 32'hFFFF_FFFF);
        quiesce();
        write_vertex_count(9'd4);
        send_edge(1'b1, 8'd3, 8'd0, 32'hFFFF_FFFB);
        send_edge(1'b0, 8'd1, 8'd2, 32'hFFFF_FFFC);
        send_edge(1'b0, 8'd2, 8'd1, 32'hFFFF_FFFD);
        send_edge(1'b0, 8'd0, 8'd4, 32'hFFFF_FFFE);
        send_edge(1'b0, 8'd9, 8'd1, 32'hFFFF_FFFF);
        send_edge(1'b0, 8'd1, 8'd3, 32'h0000_0000);
        send_edge(1'b0, 8'd0, 8'd2, 32'h0000_0001);
        quiesce();
        write_vertex_count(9'd1);
        send_edge(1'b1, 8'd0, 8'd0, 32'h0000_0000);
        send_edge(1'b0, 8'd0, 8'd1, 32'h0000_0000);
        quiesce();
        write_vertex_count(9'd0);
        send_edge(1'b1, 8'd0, 8'd0, 32'h0000_0005);
        quiesce();
        write_vertex_count(9'd511);
        send_edge(1'b1, 8'd200, 8'd100, 32'h5555_5555);
        send_edge(1'b0, 8'd255, 8'd254, 32'hAAAA_AAAA);
        quiesce();
        // shrink the count with the forest kept: already complete
        write_vertex_count(9'd3);
        send_edge(1'b0, 8'd1, 8'd2, 32'h1234_5678);
        send_edge(1'b0, 8'd0, 8'd1, 32'h1234_5679);
    endtask

    initial begin : stimulus
        int unsigned target, vc, budget, phase_start, r;
        bit          big_done, start_hold;
        tree_sb  = new();
        big_done = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 6;
        dst_idle_pct = 46;
        run_directed();

        for (int m = 0; m < 3; m++) begin
            // idling pattern per third of the run
            case (m)
                0: begin src_idle_pct = 6;  dst_idle_pct = 46; end
                1: begin src_idle_pct = 46; dst_idle_pct = 6;  end
                default: begin src_idle_pct = 0; dst_idle_pct = 0; end
            endcase
            target = 530 * (m + 1) - 40 * (m / 2);
            while (items_sent < target) begin
                start_hold = 1'b0;
                if (m == 2 && !big_done) begin
                    // full-size graph, run under the long output hold
                    vc = VERT_LIMIT;
                    budget = 420;
                    big_done = 1'b1;
                    start_hold = 1'b1;
                end else begin
                    r = $urandom_range(99);
                    if (r < 60)      vc = $urandom_range(2, 12);
                    else if (r < 75) vc = $urandom_range(13, 48);
                    else if (r < 82) vc = 1;
                    else if (r < 86) vc = 0;
                    else if (r < 94) vc = $urandom_range(257, 511);
                    else             vc = $urandom_range(49, 255);
                    budget = $urandom_range(40, 110);
                end
                quiesce();
                write_vertex_count(vc[CNT_W-1:0]);
                if (start_hold) hold_go = 1'b1;
                phase_start = items_sent;
                while (items_sent - phase_start < budget)
                    send_graph(vc, budget - (items_sent - phase_start));
            end
        end

        quiesce();
        $display("run covered %0d edges in %0d graphs over %0d vertex_count settings",
                 items_sent, graphs_sent, vc_writes);
        $display("%0d tree edges matched, %0d mismatches", tree_sb.matched, tree_sb.errors);
        if (tree_sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/kuf_pkg.sv
hw/rtl/kuf_parent_mem.sv
hw/rtl/kruskal_union_find_edge_filter.sv
sim/tb_top.sv
